// File: hw/rtl/rbts_pkg.sv
`default_nettype none
package rbts_pkg;

    // configuration register indexes
    localparam logic REG_RISK_LEVEL  = 1'b0;
    localparam logic REG_ALERT_DELAY = 1'b1;

    localparam int CFG_DATA_BITS = 11;
    localparam int RISK_BITS     = 6;
    localparam int DELAY_BITS    = 11;
    localparam int DELAY_SEC_BITS = 17;

    localparam logic [RISK_BITS-1:0] RISK_MAX = 6'd33;
    localparam int PCT_SCALE   = 100;
    localparam int SEC_PER_MIN = 60;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } trade_sig_t;

    // per-bar control carried alongside the prices
    typedef struct packed {
        logic series_start;
        logic series_end;
        logic full;
        logic enough;
        logic late;
    } bar_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/rbts_cell.sv
`default_nettype none
module rbts_cell #(
    parameter int PW = 32
) (
    input  wire logic          clk,
    input  wire logic          shift_en,
    input  wire logic [PW-1:0] new_high,
    input  wire logic [PW-1:0] new_low,
    input  wire logic [PW-1:0] prev_max,
    input  wire logic [PW-1:0] prev_min,
    output logic      [PW-1:0] run_max,
    output logic      [PW-1:0] run_min
);

    logic [PW-1:0] max_reg;
    logic [PW-1:0] min_reg;
    logic [PW-1:0] max_next;
    logic [PW-1:0] min_next;

    // cell i holds max/min of the newest i+1 bars
    always_comb
    begin
        max_next = (new_high > prev_max) ? new_high : prev_max;
        min_next = (new_low < prev_min) ? new_low : prev_min;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

    assign run_max = max_reg;
    assign run_min = min_reg;

endmodule
`default_nettype wire

// File: hw/rtl/rbts_band.sv
`default_nettype none
module rbts_band
    import rbts_pkg::*;
#(
    parameter int PW = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire bar_ctl_t             ctl,
    input  wire logic [PW-1:0]        close_price,
    input  wire logic [PW-1:0]        win_max,
    input  wire logic [PW-1:0]        win_min,
    input  wire logic [RISK_BITS-1:0] k_pct,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic                      window_full,
    output logic                      trend_up,
    output logic [1:0]                trade_signal
);

    localparam int LW = PW + 9;

    logic signed [PW:0]   range_s;
    logic signed [PW+7:0] rk;
    logic [PW+6:0]        min100;
    logic [PW+6:0]        max100;
    logic [PW+6:0]        c100;

    logic                 v2_reg;
    bar_ctl_t             ctl2_reg;
    logic signed [PW+7:0] rk_reg;
    logic [PW+6:0]        min100_reg;
    logic [PW+6:0]        max100_reg;
    logic [PW+6:0]        c100_reg;

    logic                 out_valid_reg;
    logic                 full_reg;
    logic                 flag_reg;
    trade_sig_t           sig_reg;

    logic                 ld_out;
    logic signed [LW-1:0] lower;
    logic signed [LW-1:0] upper;
    logic signed [LW-1:0] c100_s;
    logic                 prev_flag;
    logic                 flag_next;
    trade_sig_t           sig_next;

    assign ld_out   = !out_valid_reg || !result_stall;
    assign up_ready = !v2_reg || ld_out;

    // stage 2 operands: range scaled by k and the x100 prices
    always_comb
    begin
        range_s = $signed({1'b0, win_max}) - $signed({1'b0, win_min});
        rk      = (PW+8)'(range_s) * (PW+8)'($signed({1'b0, k_pct}));
        min100  = (PW+7)'(win_min) * (PW+7)'(PCT_SCALE);
        max100  = (PW+7)'(win_max) * (PW+7)'(PCT_SCALE);
        c100    = (PW+7)'(close_price) * (PW+7)'(PCT_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v2_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctl2_reg   <= ctl;
            rk_reg     <= rk;
            min100_reg <= min100;
            max100_reg <= max100;
            c100_reg   <= c100;
        end
    end

    // band compare and trend update, flag lives here so bars stay in order
    always_comb
    begin
        lower  = $signed({2'b00, min100_reg}) + LW'(rk_reg);
        upper  = $signed({2'b00, max100_reg}) - LW'(rk_reg);
        c100_s = $signed({2'b00, c100_reg});
        prev_flag = ctl2_reg.series_start ? 1'b0 : flag_reg;
        flag_next = prev_flag;
        sig_next  = SIG_NONE;
        if (ctl2_reg.full)
        begin
            if (c100_s > upper)
            begin
                flag_next = 1'b1;
            end
            else if (c100_s < lower)
            begin
                flag_next = 1'b0;
            end
            if (ctl2_reg.series_end && ctl2_reg.enough && ctl2_reg.late
                && (flag_next != prev_flag))
            begin
                sig_next = flag_next ? SIG_BUY : SIG_SELL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else if (ld_out)
        begin
            out_valid_reg <= v2_reg;
            if (v2_reg)
            begin
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out && v2_reg)
        begin
            full_reg <= ctl2_reg.full;
            sig_reg  <= sig_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign window_full  = full_reg;
    assign trend_up     = flag_reg;
    assign trade_signal = sig_reg;

endmodule
`default_nettype wire

// File: hw/rtl/range_band_trend_signal.sv
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// bar      | bar_valid / bar_stall | series_start series_end bar_high bar_low
//          |                       | bar_close elapsed_seconds
// result   | result_valid /        | window_full trend_up trade_signal
//          | result_stall          |
// cfg      | cfg_valid / cfg_ready | cfg_index cfg_data (always ready)
//
// one bar per cycle sustained while result_stall stays low; a result passes the stage 1, stage 2 and output registers
// the row of max/min cells shifts once per bar, loading together with the stage 1 registers
// reset clears pipeline valids, bar count, trend flag and alert delay, and sets risk level to 3
// bar_stall rises only when every stage is full and result_stall is held
`default_nettype none
module range_band_trend_signal
    import rbts_pkg::*;
#(
    parameter int WINDOW_BARS = 9,
    parameter int PRICE_BITS  = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     bar_valid,
    output logic                          bar_stall,
    input  wire logic                     series_start,
    input  wire logic                     series_end,
    input  wire logic [31:0]              bar_high,
    input  wire logic [31:0]              bar_low,
    input  wire logic [31:0]              bar_close,
    input  wire logic [31:0]              elapsed_seconds,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic                          window_full,
    output logic                          trend_up,
    output logic [1:0]                    trade_signal,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int PW      = PRICE_BITS;
    localparam int BarsCap = (WINDOW_BARS + 2 > 15) ? WINDOW_BARS + 2 : 15;
    localparam int CntW    = $clog2(BarsCap + 1);

    logic [RISK_BITS-1:0]      risk_reg;
    logic [DELAY_BITS-1:0]     delay_reg;
    logic [CntW-1:0]           bars_seen_reg;
    logic [CntW-1:0]           bars_base;
    logic [CntW-1:0]           bars_next;

    logic                      v1_reg;
    bar_ctl_t                  ctl1_reg;
    bar_ctl_t                  ctl1_next;
    logic [PW-1:0]             close_reg;

    logic                      ld1;
    logic                      accept;
    logic                      up_ready;
    logic [PW-1:0]             hi_p;
    logic [PW-1:0]             lo_p;
    logic [DELAY_SEC_BITS-1:0] delay_sec;
    logic [RISK_BITS-1:0]      k_pct;

    logic [PW-1:0]             cell_max [WINDOW_BARS];
    logic [PW-1:0]             cell_min [WINDOW_BARS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            risk_reg  <= 6'd3;
            delay_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RISK_LEVEL:  risk_reg  <= cfg_data[RISK_BITS-1:0];
                REG_ALERT_DELAY: delay_reg <= cfg_data[DELAY_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign ld1       = !v1_reg || up_ready;
    assign bar_stall = !ld1;
    assign accept    = bar_valid && ld1;

    assign hi_p = PW'(bar_high);
    assign lo_p = PW'(bar_low);

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_BARS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                rbts_cell #(.PW(PW)) u_cell (
                    .clk      (clk),
                    .shift_en (accept),
                    .new_high (hi_p),
                    .new_low  (lo_p),
                    .prev_max (hi_p),
                    .prev_min (lo_p),
                    .run_max  (cell_max[gi]),
                    .run_min  (cell_min[gi])
                );
            end
            else
            begin : g_body
                rbts_cell #(.PW(PW)) u_cell (
                    .clk      (clk),
                    .shift_en (accept),
                    .new_high (hi_p),
                    .new_low  (lo_p),
                    .prev_max (cell_max[gi-1]),
                    .prev_min (cell_min[gi-1]),
                    .run_max  (cell_max[gi]),
                    .run_min  (cell_min[gi])
                );
            end
        end
    endgenerate

    // bar count and per-bar flags, worked out as the beat comes in
    always_comb
    begin
        bars_base = series_start ? '0 : bars_seen_reg;
        bars_next = (bars_base < CntW'(BarsCap)) ? bars_base + CntW'(1) : bars_base;
        delay_sec = DELAY_SEC_BITS'(delay_reg) * DELAY_SEC_BITS'(SEC_PER_MIN);
        ctl1_next.series_start = series_start;
        ctl1_next.series_end   = series_end;
        ctl1_next.full         = bars_next >= CntW'(WINDOW_BARS);
        ctl1_next.enough       = bars_next > CntW'(WINDOW_BARS + 1);
        ctl1_next.late         = elapsed_seconds > 32'(delay_sec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            bars_seen_reg <= '0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= bar_valid;
            end
            if (accept)
            begin
                bars_seen_reg <= bars_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl1_reg  <= ctl1_next;
            close_reg <= PW'(bar_close);
        end
    end

    assign k_pct = (risk_reg > RISK_MAX) ? '0 : RISK_MAX - risk_reg;

    // last cell spans the whole window; it only moves when stage 1 takes a new bar
    rbts_band #(.PW(PW)) u_band (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (v1_reg),
        .up_ready     (up_ready),
        .ctl          (ctl1_reg),
        .close_price  (close_reg),
        .win_max      (cell_max[WINDOW_BARS-1]),
        .win_min      (cell_min[WINDOW_BARS-1]),
        .k_pct        (k_pct),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_full  (window_full),
        .trend_up     (trend_up),
        .trade_signal (trade_signal)
    );

`ifndef SYNTHESIS
    a_sig_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (trade_signal != SIG_NONE)) |-> window_full)
        else $error("trade signal without a full window");

    a_sig_matches_trend: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ((trade_signal == SIG_BUY) || (trade_signal == SIG_SELL)))
        |-> (trend_up == (trade_signal == SIG_BUY)))
        else $error("signal direction disagrees with trend flag");

    a_empty_stage_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !bar_stall)
        else $error("bar stalled with first stage empty");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        bars_seen_reg <= CntW'(BarsCap))
        else $error("bar count beyond cap");
`endif

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench
    import rbts_pkg::*;
();

    localparam int WIN_BARS     = 9;
    localparam int BAR_CAP      = 15;
    localparam int LAT_CYCLES   = 6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_BARS   = 215;

    typedef struct {
        logic        is_first;
        logic        is_last;
        logic [31:0] hi_px;
        logic [31:0] lo_px;
        logic [31:0] cl_px;
        logic [31:0] elapsed_s;
    } bar_t;

    typedef struct {
        logic       full;
        logic       up;
        trade_sig_t sig;
    } band_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     bar_valid = 1'b0;
    logic                     series_start = 1'b0;
    logic                     series_end = 1'b0;
    logic [31:0]              bar_high = '0;
    logic [31:0]              bar_low = '0;
    logic [31:0]              bar_close = '0;
    logic [31:0]              elapsed_seconds = '0;
    logic                     result_stall = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_index = REG_RISK_LEVEL;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic       bar_stall;
    logic       result_valid;
    logic       window_full;
    logic       trend_up;
    logic [1:0] trade_signal;
    logic       cfg_ready;

    range_band_trend_signal u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .bar_valid       (bar_valid),
        .bar_stall       (bar_stall),
        .series_start    (series_start),
        .series_end      (series_end),
        .bar_high        (bar_high),
        .bar_low         (bar_low),
        .bar_close       (bar_close),
        .elapsed_seconds (elapsed_seconds),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .window_full     (window_full),
        .trend_up        (trend_up),
        .trade_signal    (trade_signal),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of the block's state and registers
    logic [RISK_BITS-1:0]  risk_cfg = 6'd3;
    logic [DELAY_BITS-1:0] delay_cfg = '0;
    logic [31:0]           hi_win [WIN_BARS];
    logic [31:0]           lo_win [WIN_BARS];
    logic [3:0]            bars_in_series = '0;
    logic                  trend_flag = 1'b0;

    bar_t         pending_bars [$];
    band_result_t band_expected [$];
    bar_t         bar_cur;
    int           bar_idle_pct = 0;
    int           result_stall_pct = 0;
    int           bars_queued = 0;
    int           errors = 0;
    int           cycles = 0;

    function automatic band_result_t step_band(bar_t b);
        band_result_t r;
        logic [31:0]  wmax;
        logic [31:0]  wmin;
        longint       wmax_l, wmin_l, cl_l, el_l, thr_l, rng, k, lower, upper;
        logic         prev;
        begin
            if (b.is_first) begin
                for (int i = 0; i < WIN_BARS; i++) begin
                    hi_win[i] = '0;
                    lo_win[i] = '0;
                end
                bars_in_series = '0;
                trend_flag = 1'b0;
            end
            for (int i = WIN_BARS - 1; i > 0; i--) begin
                hi_win[i] = hi_win[i-1];
                lo_win[i] = lo_win[i-1];
            end
            hi_win[0] = b.hi_px;
            lo_win[0] = b.lo_px;
            if (bars_in_series < BAR_CAP)
                bars_in_series++;
            r.full = 1'b0;
            r.sig = SIG_NONE;
            if (bars_in_series >= WIN_BARS) begin
                wmax = hi_win[0];
                wmin = lo_win[0];
                for (int i = 1; i < WIN_BARS; i++) begin
                    if (hi_win[i] > wmax) wmax = hi_win[i];
                    if (lo_win[i] < wmin) wmin = lo_win[i];
                end
                wmax_l = wmax;
                wmin_l = wmin;
                cl_l = b.cl_px;
                el_l = b.elapsed_s;
                thr_l = delay_cfg;
                thr_l = thr_l * SEC_PER_MIN;
                k = (risk_cfg > RISK_MAX) ? 0 : 33 - longint'(risk_cfg);
                rng = wmax_l - wmin_l;
                // range may be negative when highs sit below lows
                lower = PCT_SCALE * wmin_l + rng * k;
                upper = PCT_SCALE * wmax_l - rng * k;
                prev = trend_flag;
                if (PCT_SCALE * cl_l < lower) trend_flag = 1'b0;
                if (PCT_SCALE * cl_l > upper) trend_flag = 1'b1;
                r.full = 1'b1;
                if (b.is_last && trend_flag != prev && bars_in_series > WIN_BARS + 1
                    && el_l > thr_l)
                    r.sig = trend_flag ? SIG_BUY : SIG_SELL;
            end
            r.up = trend_flag;
            return r;
        end
    endfunction

    always @(posedge clk)
    begin : bar_driver
        if (rst_n) begin
            if (bar_valid && !bar_stall)
                band_expected.push_back(step_band(bar_cur));
            if (!bar_valid || !bar_stall) begin
                if (pending_bars.size() > 0 && $urandom_range(99) >= bar_idle_pct) begin
                    bar_cur = pending_bars.pop_front();
                    bar_valid <= 1'b1;
                    series_start <= bar_cur.is_first;
                    series_end <= bar_cur.is_last;
                    bar_high <= bar_cur.hi_px;
                    bar_low <= bar_cur.lo_px;
                    bar_close <= bar_cur.cl_px;
                    elapsed_seconds <= bar_cur.elapsed_s;
                end
                else begin
                    bar_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        band_result_t want;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                if (band_expected.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end
                else begin
                    want = band_expected.pop_front();
                    if (window_full !== want.full) begin
                        $display("%0t: window_full expected %0d got %0d",
                                 $time, want.full, window_full);
                        errors++;
                    end
                    if (trend_up !== want.up) begin
                        $display("%0t: trend_up expected %0d got %0d",
                                 $time, want.up, trend_up);
                        errors++;
                    end
                    if (trade_signal !== want.sig) begin
                        $display("%0t: trade_signal expected %0d got %0d",
                                 $time, want.sig, trade_signal);
                        errors++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < result_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_bar(input logic first, input logic last, input logic [31:0] hi,
                            input logic [31:0] lo, input logic [31:0] cl,
                            input logic [31:0] el);
        bar_t b;
        begin
            b.is_first = first;
            b.is_last = last;
            b.hi_px = hi;
            b.lo_px = lo;
            b.cl_px = cl;
            b.elapsed_s = el;
            pending_bars.push_back(b);
            bars_queued++;
        end
    endtask

    // elapsed time around the alert threshold on a series' last bar
    function automatic logic [31:0] pick_elapsed();
        logic [31:0] thr;
        begin
            thr = delay_cfg;
            thr = thr * SEC_PER_MIN;
            case ($urandom_range(3))
                0: return thr;
                1: return thr + 1;
                2: return $urandom_range(thr);
                default: return $urandom;
            endcase
        end
    endfunction

    task automatic push_series(input int n);
        logic [31:0] base;
        logic [31:0] spread;
        logic [31:0] cl;
        logic        last;
        begin
            base = $urandom_range(32'hFFF0_0000, 32'h0010_0000);
            spread = ($urandom_range(3) == 0) ? $urandom_range(32'h3FFFF)
                                              : $urandom_range(255);
            for (int i = 0; i < n; i++) begin
                if (i == n - 1 || $urandom_range(9) < 2) begin
                    // break out of the band one way or the other
                    if ($urandom_range(1))
                        cl = base + spread + 1 + $urandom_range(spread);
                    else
                        cl = base - spread - 1 - $urandom_range(spread);
                end
                else begin
                    cl = base - spread + $urandom_range(2 * spread);
                end
                last = (i == n - 1) || ($urandom_range(19) == 0);
                push_bar(i == 0, last, base + $urandom_range(spread),
                         base - $urandom_range(spread), cl,
                         last ? pick_elapsed() : $urandom);
            end
        end
    endtask

    task automatic wait_idle();
        begin
            @(negedge clk);
            while (pending_bars.size() != 0 || bar_valid || band_expected.size() != 0)
                @(negedge clk);
            repeat (LAT_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] val);
        begin
            @(posedge clk);
            cfg_index <= idx;
            cfg_data <= val;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_valid <= 1'b0;
            if (idx == REG_RISK_LEVEL)
                risk_cfg = val[RISK_BITS-1:0];
            else
                delay_cfg = val[DELAY_BITS-1:0];
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_BITS-1:0] risk_data [6];
        logic [CFG_DATA_BITS-1:0] delay_data [6];
        int                       n;
        int                       phase_start;
        bit                       paused;

        risk_data = '{11'd0, 11'd33, 11'h7FF, 11'd34, 11'd17, 11'd5};
        delay_data = '{11'd0, 11'd1, 11'h7FF, 11'd1440, 11'd5, 11'd3};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed bars under the reset register values
        bar_idle_pct = 35;
        result_stall_pct = 62;
        push_bar(1, 1, '1, '0, '1, '1);
        push_bar(1, 0, '1, '0, 32'h8000_0000, '0);
        for (int i = 0; i < 7; i++)
            push_bar(0, 0, '1, '0, 32'h8000_0000, '0);
        push_bar(0, 0, '1, '0, '0, '0);
        push_bar(0, 0, '1, '0, '1, '0);
        push_bar(0, 1, '1, '0, '0, '1);
        // series carries on after its end mark; a flip too soon after an alert
        push_bar(0, 1, '1, '0, '1, '0);
        push_bar(0, 1, '1, '0, '1, '1);
        push_bar(0, 1, '0, '1, 32'd5, '1);
        push_bar(1, 0, 32'd1000, 32'd100, '0, '0);
        for (int i = 0; i < 8; i++)
            push_bar(0, 0, 32'd1000, 32'd100, '0, '0);
        // flip on the tenth bar: not enough bars for a signal
        push_bar(0, 1, 32'd1000, 32'd100, 32'd5000, '1);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            if (ph == 5) begin
                risk_data[ph] = CFG_DATA_BITS'($urandom_range(63));
                delay_data[ph] = CFG_DATA_BITS'($urandom_range(2047));
            end
            write_reg(REG_RISK_LEVEL, risk_data[ph]);
            write_reg(REG_ALERT_DELAY, delay_data[ph]);
            case (ph % 3)
                0: begin bar_idle_pct = 35; result_stall_pct = 62; end
                1: begin bar_idle_pct = 62; result_stall_pct = 35; end
                default: begin bar_idle_pct = 0; result_stall_pct = 0; end
            endcase
            phase_start = bars_queued;
            paused = 1'b0;
            while (bars_queued - phase_start < PHASE_BARS) begin
                if (!paused && bars_queued - phase_start >= PHASE_BARS / 2) begin
                    // sender holds off until the block has emptied
                    wait_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 12) begin
                    push_bar(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                             $urandom, $urandom, $urandom);
                end
                else begin
                    case ($urandom_range(9))
                        0: n = $urandom_range(8, 3);
                        1: n = $urandom_range(40, 17);
                        default: n = $urandom_range(16, 9);
                    endcase
                    push_series(n);
                end
            end
        end

        wait_idle();
        repeat (LAT_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
